### hdl/lphm_pkg.sv
// Shared types and constants for the linear-probe hash map core.
// No dependencies; imported by the controller, datapath and top level.
package lphm_pkg;

	localparam int SLOTS_DEF = 1024;
	localparam logic [31:0] HASH_MULT = 32'd2654435761;

	localparam logic [2:0] ST_FOUND     = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_INSERTED  = 3'd2;
	localparam logic [2:0] ST_DUPLICATE = 3'd3;
	localparam logic [2:0] ST_REFUSED   = 3'd4;

	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_INSERT = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic clear_wr;   // clearing pass: zero one key slot
		logic load;       // capture request transaction
		logic start;      // probe address <= home slot
		logic step;       // probe address <= next slot
		logic finish;     // load result register, commit insert
	} lphm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;   // last slot of clearing pass
		logic resolved;   // probe outcome known for current slot
		logic out_free;   // result register can take a new result
	} lphm_stat_t;

endpackage

### hdl/lphm_ctrl.sv
// Sequencing controller for the hash map: clearing pass, accept, probe loop.
// Depends on lphm_pkg for the command and status structs.
module lphm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  lphm_pkg::lphm_stat_t stat,
	output lphm_pkg::lphm_cmd_t  cmd
);
	import lphm_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_CMP   = 3'd4;

	logic [2:0] state_q, state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_HASH;
				end
			end
			S_HASH: begin
				cmd.start = 1'b1;
				state_d   = S_READ;
			end
			S_READ: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (!stat.resolved) begin
					cmd.step = 1'b1;
					state_d  = S_READ;
				end else if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

endmodule

### hdl/lphm_dp.sv
// Datapath: request registers, hash, key/value slot stores, compare,
// occupancy count and result register. Depends on lphm_pkg.
module lphm_dp #(
	parameter int SLOTS = lphm_pkg::SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lphm_pkg::lphm_cmd_t  cmd,
	output lphm_pkg::lphm_stat_t stat,
	input  logic [63:0]          s_tdata,
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,
	output logic [2:0]           m_tuser
);
	import lphm_pkg::*;

	localparam int ADDR_W = $clog2(SLOTS);
	localparam logic [ADDR_W-1:0] HALF = ADDR_W'(SLOTS / 2);
	localparam logic [ADDR_W-1:0] LAST = ADDR_W'(SLOTS - 1);
	localparam logic [ADDR_W-1:0] MULT_LO = HASH_MULT[ADDR_W-1:0];

	logic [31:0] slot_keys [SLOTS];
	logic [31:0] slot_values [SLOTS];

	logic              action_q;
	logic [31:0]       key_q, val_q;
	logic [ADDR_W-1:0] addr_q, clr_q, occ_q;
	logic [31:0]       rd_key_q, rd_val_q;
	logic              out_valid_q;
	logic [2:0]        out_status_q;
	logic [31:0]       out_value_q;

	logic [2*ADDR_W-1:0] prod_full;
	logic                key_zero, val_zero, early, empty, hit, full, ins_ok;
	logic [2:0]          status;
	logic                key_we;
	logic [ADDR_W-1:0]   key_wa;
	logic [31:0]         key_wd;

	// only the low bits of the 32-bit product are kept, so a narrow multiply suffices
	assign prod_full = {ADDR_W'(0), key_q[ADDR_W-1:0]} * {ADDR_W'(0), MULT_LO};

	assign key_zero = (key_q == 32'd0);
	assign val_zero = (val_q == 32'd0);
	assign early    = key_zero || (action_q == ACT_INSERT && val_zero);
	assign empty    = (rd_key_q == 32'd0);
	assign hit      = !empty && (rd_key_q == key_q);
	assign full     = (occ_q >= HALF);
	assign ins_ok   = (action_q == ACT_INSERT) && !early && empty && !full;

	always_comb begin
		if (action_q == ACT_LOOKUP) begin
			status = (!key_zero && hit) ? ST_FOUND : ST_NOT_FOUND;
		end else begin
			priority if (early) status = ST_REFUSED;
			else if (hit) status = ST_DUPLICATE;
			else if (ins_ok) status = ST_INSERTED;
			else status = ST_REFUSED;
		end
	end

	assign stat.clr_last = (clr_q == LAST);
	assign stat.resolved = early || empty || hit;
	assign stat.out_free = !out_valid_q || m_tready;

	assign key_we = cmd.clear_wr || (cmd.finish && ins_ok);
	assign key_wa = cmd.clear_wr ? clr_q : addr_q;
	assign key_wd = cmd.clear_wr ? 32'd0 : key_q;

	always_ff @(posedge clk) begin
		if (key_we) slot_keys[key_wa] <= key_wd;
		rd_key_q <= slot_keys[addr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && ins_ok) slot_values[addr_q] <= val_q;
		rd_val_q <= slot_values[addr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= s_tuser;
			key_q    <= s_tdata[31:0];
			val_q    <= s_tdata[63:32];
		end
		if (cmd.start) addr_q <= prod_full[ADDR_W-1:0];
		else if (cmd.step) addr_q <= addr_q + ADDR_W'(1);
		if (cmd.finish) begin
			out_status_q <= status;
			out_value_q  <= (status == ST_FOUND) ? rd_val_q : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_wr) clr_q <= clr_q + ADDR_W'(1);
			if (cmd.finish && ins_ok) occ_q <= occ_q + ADDR_W'(1);
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = out_status_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n) occ_q <= HALF)
		else $error("occupancy above half of the slots");
	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && ins_ok |=> occ_q == $past(occ_q) + ADDR_W'(1))
		else $error("insert did not advance occupancy");
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> stat.out_free)
		else $error("result overwritten before it was taken");
	a_result_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> m_tvalid)
		else $error("finished result not presented");

endmodule

### hdl/linear_probe_hash_map_core.sv
// Linear-probe hash map core: open-addressing key/value store.
// Channels: slave stream takes requests, tdata = {entry_value, key} (key in the
// low 32 bits), tuser = action (0 lookup, 1 insert). Master stream returns one
// transaction per request, tdata = result_value, tuser = status
// (0 found, 1 not found, 2 inserted, 3 duplicate, 4 refused).
// Home slot is the low bits of key * 2654435761; probing is linear with wrap.
// Inserts are refused once half of the slots are occupied.
// Sequence: a request is captured, its home slot address is computed, then each
// slot probed is read from the registered key store and compared, until the
// result register is loaded.
// One request is in flight at a time; s_tready rises again once its result is
// loaded, even while that result still waits on m_tready.
// Reset: a clearing pass zeroes one key slot per cycle, over all SLOTS slots, with
// s_tready low throughout. If the receiver stalls, the finished result is held
// and a following request stops at its compare step until the register frees.
// Depends on lphm_pkg, lphm_ctrl, lphm_dp.
module linear_probe_hash_map_core #(
	parameter int SLOTS = lphm_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] key, [63:32] entry_value
	input  logic        s_tuser,   // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] result_value
	output logic [2:0]  m_tuser    // [2:0] status
);
	import lphm_pkg::*;

	lphm_cmd_t  cmd;
	lphm_stat_t stat;

	lphm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lphm_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

### verif/tb_linear_probe_hash_map_core.sv
// Self-checking testbench for linear_probe_hash_map_core: directed table, then random traffic.
// A behavioural copy of the map predicts every result transaction except those of directed rows with a typed result.
// Depends on lphm_pkg and the core RTL.
module tb_linear_probe_hash_map_core;
	import lphm_pkg::*;

	localparam int SLOTS  = SLOTS_DEF;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int N_RAND = 1100;
	localparam int DRAIN  = 64;
	// clearing pass, ~1100 requests with long probes near half load, gaps and stalls,
	// all taken several times over
	localparam int LIMIT  = 1000000;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] value;
	} map_res_t;

	typedef struct packed {
		logic        act;
		logic [31:0] key;
		logic [31:0] val;
		bit          typed;
		map_res_t    want;
	} dir_row_t;

	localparam int N_DIR = 22;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // [31:0] key, [63:32] entry_value
	logic        s_tuser;   // [0] action
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [31:0] result_value
	logic [2:0]  m_tuser;   // [2:0] status

	linear_probe_hash_map_core #(.SLOTS(SLOTS)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// shadow copy of the table
	logic [31:0] shadow_keys [SLOTS];
	logic [31:0] shadow_vals [SLOTS];
	int          shadow_occ;

	map_res_t    pending_results [$];
	logic [31:0] key_pool [$];
	int          mismatches;
	int          results_seen;
	int          sent;
	int          burst_left;
	int          cycle_cnt;
	int          status_cnt [5];

	// rows with a typed result are obvious from the spec; the rest go through the shadow map
	dir_row_t dir_rows [N_DIR] = '{
		{ACT_LOOKUP, 32'd1,          32'd0,          1'b1, ST_NOT_FOUND, 32'd0},
		{ACT_LOOKUP, 32'd0,          32'd0,          1'b1, ST_NOT_FOUND, 32'd0},
		{ACT_INSERT, 32'd0,          32'd5,          1'b1, ST_REFUSED,   32'd0},
		{ACT_INSERT, 32'd5,          32'd0,          1'b1, ST_REFUSED,   32'd0},
		{ACT_INSERT, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, ST_INSERTED,  32'd0},
		{ACT_LOOKUP, 32'hFFFF_FFFF,  32'd0,          1'b1, ST_FOUND,     32'hFFFF_FFFF},
		{ACT_INSERT, 32'hFFFF_FFFF,  32'd1,          1'b1, ST_DUPLICATE, 32'd0},
		{ACT_LOOKUP, 32'd0,          32'hFFFF_FFFF,  1'b1, ST_NOT_FOUND, 32'd0},
		{ACT_INSERT, 32'd1,          32'd1,          1'b1, ST_INSERTED,  32'd0},
		{ACT_LOOKUP, 32'd1,          32'd0,          1'b1, ST_FOUND,     32'd1},
		// 1, 1025 and 2049 share a home slot
		{ACT_INSERT, 32'd1025,       32'hA5A5_A5A5,  1'b0, ST_FOUND,     32'd0},
		{ACT_LOOKUP, 32'd1025,       32'd0,          1'b0, ST_FOUND,     32'd0},
		{ACT_LOOKUP, 32'd2049,       32'd0,          1'b0, ST_FOUND,     32'd0},
		{ACT_INSERT, 32'd2049,       32'h5A5A_5A5A,  1'b0, ST_FOUND,     32'd0},
		// 175 and 1199 hash to the last slot, so 1199 wraps to slot 0
		{ACT_INSERT, 32'd175,        32'h1234_5678,  1'b0, ST_FOUND,     32'd0},
		{ACT_INSERT, 32'd1199,       32'h8765_4321,  1'b0, ST_FOUND,     32'd0},
		{ACT_LOOKUP, 32'd1199,       32'd0,          1'b0, ST_FOUND,     32'd0},
		{ACT_INSERT, 32'd1024,       32'd2,          1'b0, ST_FOUND,     32'd0},
		{ACT_LOOKUP, 32'd1024,       32'd0,          1'b0, ST_FOUND,     32'd0},
		{ACT_LOOKUP, 32'd175,        32'd0,          1'b0, ST_FOUND,     32'd0},
		{ACT_INSERT, 32'h8000_0000,  32'h7FFF_FFFF,  1'b1, ST_INSERTED,  32'd0},
		{ACT_LOOKUP, 32'h8000_0000,  32'd0,          1'b1, ST_FOUND,     32'h7FFF_FFFF}
	};

	function automatic logic [SLOT_W-1:0] home_of(logic [31:0] k);
		logic [31:0] h;
		h = k * HASH_MULT;
		return h[SLOT_W-1:0];
	endfunction

	// applies one request to the shadow map and returns the result it gives
	function automatic map_res_t map_apply(logic act, logic [31:0] k, logic [31:0] v);
		map_res_t          r;
		logic [SLOT_W-1:0] idx;
		bit                hit;
		bit                hole;
		r.status = ST_NOT_FOUND;
		r.value  = '0;
		hit      = 1'b0;
		hole     = 1'b0;
		idx      = home_of(k);
		if (k != 0) begin
			for (int n = 0; n < SLOTS && !hit && !hole; n++) begin
				if (shadow_keys[idx] == 0)
					hole = 1'b1;
				else if (shadow_keys[idx] == k)
					hit = 1'b1;
				else
					idx = idx + 1'b1;
			end
		end
		if (act == ACT_LOOKUP) begin
			if (hit) begin
				r.status = ST_FOUND;
				r.value  = shadow_vals[idx];
			end
		end else if (k == 0 || v == 0) begin
			r.status = ST_REFUSED;
		end else if (hit) begin
			r.status = ST_DUPLICATE;
		end else if ((shadow_occ + 1) * 2 > SLOTS || !hole) begin
			r.status = ST_REFUSED;
		end else begin
			shadow_keys[idx] = k;
			shadow_vals[idx] = v;
			shadow_occ++;
			r.status = ST_INSERTED;
		end
		return r;
	endfunction

	// mostly random keys, some forced onto the home slot of a stored key, some small
	function automatic logic [31:0] fresh_key();
		int sel;
		sel = $urandom_range(99);
		if (sel < 25 && key_pool.size() != 0)
			return key_pool[$urandom_range(key_pool.size() - 1)] + 32'(SLOTS * $urandom_range(1, 7));
		else if (sel < 40)
			return 32'($urandom_range(1, 4095));
		else
			return $urandom;
	endfunction

	// sender bursts with random gaps between them
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic offer(input logic act, input logic [31:0] k, input logic [31:0] v,
			input bit typed, input map_res_t want);
		map_res_t got;
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {v, k};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		got = map_apply(act, k, v);
		if (got.status == ST_INSERTED)
			key_pool = {key_pool, k};
		pending_results = {pending_results, (typed ? want : got)};
		sent++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("FAILURE");
		$finish;
	end

	// receiver: switches between random stall patterns, with one long hold-off
	initial begin : receiver
		int  mode;
		int  mode_left;
		bit  held_off;
		mode      = 0;
		mode_left = 0;
		held_off  = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held_off && results_seen >= 300) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(3);
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(1));
				2: m_tready <= ($urandom_range(7) != 0);
				default: m_tready <= ($urandom_range(7) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		map_res_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing expected: status %0d value %h",
					m_tuser, m_tdata);
				mismatches++;
			end else begin
				exp_r = pending_results.pop_front();
				if (m_tuser != exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, m_tuser);
					mismatches++;
				end
				if (m_tdata != exp_r.value) begin
					$error("result_value: expected %h, got %h", exp_r.value, m_tdata);
					mismatches++;
				end
				if (exp_r.status <= ST_REFUSED)
					status_cnt[exp_r.status]++;
			end
		end
	end

	initial begin : stimulus
		int          pick;
		logic        act;
		logic [31:0] k;
		logic [31:0] v;
		mismatches   = 0;
		results_seen = 0;
		sent         = 0;
		burst_left   = 0;
		shadow_occ   = 0;
		for (int i = 0; i < 5; i++)
			status_cnt[i] = 0;
		for (int i = 0; i < SLOTS; i++) begin
			shadow_keys[i] = '0;
			shadow_vals[i] = '0;
		end
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIR; i++) begin
			pace();
			offer(dir_rows[i].act, dir_rows[i].key, dir_rows[i].val,
				dir_rows[i].typed, dir_rows[i].want);
		end

		for (int i = 0; i < N_RAND; i++) begin
			// sender waits for the block to drain completely once
			if (i == 500) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0) @(posedge clk);
			end
			pick = $urandom_range(99);
			v    = $urandom;
			if (pick < 60) begin
				act = ACT_INSERT;
				k   = fresh_key();
				if (v == 0)
					v = 32'd1;
			end else if (pick < 80 && key_pool.size() != 0) begin
				act = ACT_LOOKUP;
				k   = key_pool[$urandom_range(key_pool.size() - 1)];
			end else if (pick < 86) begin
				act = ACT_LOOKUP;
				k   = fresh_key();
			end else if (pick < 92 && key_pool.size() != 0) begin
				act = ACT_INSERT;
				k   = key_pool[$urandom_range(key_pool.size() - 1)];
			end else if (pick < 96) begin
				// zero key or zero value on insert
				act = ACT_INSERT;
				k   = fresh_key();
				if ($urandom_range(1))
					k = '0;
				else
					v = '0;
			end else begin
				act = ACT_LOOKUP;
				k   = '0;
			end
			pace();
			offer(act, k, v, 1'b0, '0);
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("%0d requests after the clearing pass, %0d slots filled of %0d;",
			sent, shadow_occ, SLOTS);
		$display("outcomes: %0d found, %0d not found, %0d inserted, %0d duplicate, %0d refused",
			status_cnt[ST_FOUND], status_cnt[ST_NOT_FOUND], status_cnt[ST_INSERTED],
			status_cnt[ST_DUPLICATE], status_cnt[ST_REFUSED]);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
